### hdl/l2u_pkg.sv
package l2u_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int JOB_BYTES   = 4;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] LEAD_MASK  = 8'hFE;
    localparam logic [7:0] LEAD_BASE  = 8'hC2;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_BASE  = 8'h80;
    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] TWO_LEAD   = 8'hC0;
    localparam logic [7:0] BIT6_CLEAR = 8'hBF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } out_word_t;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      last;
    } job_t;

endpackage

### hdl/l2u_front.sv
module l2u_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              latin_valid,
    output logic              latin_stall,
    input  l2u_pkg::in_word_t latin_word,
    input  logic              q_full,
    output logic              q_push,
    output l2u_pkg::job_t     q_job
);
    import l2u_pkg::*;

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       discarding_reg, discarding_next;
    logic       accept;

    assign latin_stall = q_full;
    assign accept      = latin_valid && !q_full;

    always_comb
    begin
        logic [7:0] b;
        logic       consumed;
        logic [2:0] n;
        logic [JOB_BYTES-1:0][7:0] bytes;
        b        = latin_word.data_byte;
        consumed = 1'b0;
        n        = 3'd0;
        bytes    = '0;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        discarding_next = discarding_reg;
        if (!discarding_reg)
        begin
            if (held_valid_reg)
            begin
                if ((b & CONT_MASK) == CONT_BASE)
                begin
                    bytes[0] = held_byte_reg;
                    bytes[1] = b;
                    consumed = 1'b1;
                end
                else
                begin
                    bytes[0] = TWO_LEAD | {6'd0, held_byte_reg[7:6]};
                    bytes[1] = held_byte_reg & BIT6_CLEAR;
                end
                n = 3'd2;
                held_valid_next = 1'b0;
                held_byte_next  = 8'd0;
            end
            if (!consumed)
            begin
                if (b == BYTE_NUL)
                begin
                    discarding_next = 1'b1;
                end
                else if (b == BYTE_LF)
                begin
                    bytes[n[1:0]] = b;
                    n = n + 3'd1;
                end
                else if (b < BYTE_SPACE || b == BYTE_DEL)
                begin
                    bytes[n[1:0]] = BYTE_SPACE;
                    n = n + 3'd1;
                end
                else if ((b & LEAD_MASK) == LEAD_BASE && !latin_word.last_byte)
                begin
                    held_byte_next  = b;
                    held_valid_next = 1'b1;
                end
                else if ((b & HIGH_BIT) != 8'd0)
                begin
                    bytes[n[1:0]]        = TWO_LEAD | {6'd0, b[7:6]};
                    bytes[n[1:0] + 2'd1] = b & BIT6_CLEAR;
                    n = n + 3'd2;
                end
                else
                begin
                    bytes[n[1:0]] = b;
                    n = n + 3'd1;
                end
            end
        end
        if (latin_word.last_byte)
        begin
            held_byte_next  = 8'd0;
            held_valid_next = 1'b0;
            discarding_next = 1'b0;
        end
        q_job.bytes = bytes;
        q_job.cnt   = n;
        q_job.last  = latin_word.last_byte;
        q_push      = accept && (n != 3'd0 || latin_word.last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            discarding_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule

### hdl/l2u_queue.sv
module l2u_queue #(
    parameter int Depth = l2u_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  l2u_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output l2u_pkg::job_t head_job
);
    import l2u_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    job_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/l2u_back.sv
module l2u_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  l2u_pkg::job_t      q_head,
    output logic               q_pop,
    output logic               utf_valid,
    input  logic               utf_stall,
    output l2u_pkg::out_word_t utf_word
);
    import l2u_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_word_reg, out_word_next;
    logic       load;
    logic       final_byte;

    assign load       = !out_valid_reg || !utf_stall;
    assign final_byte = (q_head.cnt == 3'd0) || ({1'b0, idx_reg} == q_head.cnt - 3'd1);
    assign q_pop      = load && !q_empty && final_byte;
    assign utf_valid  = out_valid_reg;
    assign utf_word   = out_word_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                out_word_next.byte_valid = (q_head.cnt != 3'd0);
                out_word_next.out_byte   = (q_head.cnt != 3'd0) ? q_head.bytes[idx_reg] : 8'd0;
                out_word_next.out_last   = q_head.last && final_byte;
                idx_next = final_byte ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

### hdl/latin1_to_utf8_converter_top.sv
// latin-1 to utf-8 stream converter
// latin channel: latin_valid / latin_stall / latin_word carry one latin-1 byte
//   per word with last_byte marking the end of the string; a zero byte ends
//   the string and later bytes up to last_byte are dropped
// utf channel: utf_valid / utf_stall / utf_word carry one utf-8 byte per word;
//   out_last flags the final word of a string, a word with byte_valid low is a
//   bare end marker
// a word is taken at a rising edge with valid high and stall low
// the front classifies each input word in its accept cycle and queues a job of
//   zero to four output bytes; the back sends one byte per cycle while
//   utf_stall is low; bytes pass the job queue, then the output register
// throughput: one input word per cycle while the job queue has room; the
//   output side runs at one byte per cycle while utf_stall is low, so the
//   input rate is bound by the bytes each word produces, typically one or two
// utf_stall holds the output register; the queue absorbs up to QueueDepth
//   jobs before latin_stall rises
// reset clears the held lead byte, the discard flag, the queue and the output
module latin1_to_utf8_converter_top #(
    parameter int QueueDepth = l2u_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               latin_valid,
    output logic               latin_stall,
    input  l2u_pkg::in_word_t  latin_word,
    output logic               utf_valid,
    input  logic               utf_stall,
    output l2u_pkg::out_word_t utf_word
);
    import l2u_pkg::*;

    logic q_full, q_push, q_pop, q_empty;
    job_t q_job, q_head;

    l2u_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .latin_valid (latin_valid),
        .latin_stall (latin_stall),
        .latin_word  (latin_word),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_job)
    );

    l2u_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_head)
    );

    l2u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .utf_valid (utf_valid),
        .utf_stall (utf_stall),
        .utf_word  (utf_word)
    );

endmodule

### dv/latin1_to_utf8_converter_top_test.sv
module latin1_to_utf8_converter_top_test;

    import l2u_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 184;
    localparam int IDLE_PCT     = 18;
    localparam int DRAIN_CYCLES = 16;

    class utf_scoreboard;
        logic [7:0] held_lead;
        bit         lead_held;
        bit         dropping;
        out_word_t  expected_utf[$];
        int         checked;
        int         errors;

        task report_mismatch(string what);
            $display("mismatch after %0d utf words: %s", checked, what);
            errors++;
        endtask

        function void push_utf(logic [7:0] b);
            out_word_t w;
            w.out_byte   = b;
            w.byte_valid = 1'b1;
            w.out_last   = 1'b0;
            expected_utf.push_back(w);
        endfunction

        function void push_two_byte(logic [7:0] b);
            push_utf(TWO_LEAD | (b >> 6));
            push_utf(b & BIT6_CLEAR);
        endfunction

        function void note_latin(in_word_t w);
            int         start_size;
            bit         paired;
            logic [7:0] b;
            out_word_t  tail;
            start_size = expected_utf.size();
            paired     = 1'b0;
            b          = w.data_byte;
            if (!dropping) begin
                if (lead_held) begin
                    if ((b & CONT_MASK) == CONT_BASE) begin
                        push_utf(held_lead);
                        push_utf(b);
                        paired = 1'b1;
                    end
                    else begin
                        push_two_byte(held_lead);
                    end
                    lead_held = 1'b0;
                    held_lead = '0;
                end
                if (!paired) begin
                    if (b == BYTE_NUL)
                        dropping = 1'b1;
                    else if (b == BYTE_LF)
                        push_utf(b);
                    else if (b < BYTE_SPACE || b == BYTE_DEL)
                        push_utf(BYTE_SPACE);
                    else if ((b & LEAD_MASK) == LEAD_BASE && !w.last_byte) begin
                        held_lead = b;
                        lead_held = 1'b1;
                    end
                    else if ((b & HIGH_BIT) != '0)
                        push_two_byte(b);
                    else
                        push_utf(b);
                end
            end
            if (w.last_byte) begin
                if (expected_utf.size() == start_size) begin
                    tail.out_byte   = '0;
                    tail.byte_valid = 1'b0;
                    tail.out_last   = 1'b1;
                    expected_utf.push_back(tail);
                end
                else begin
                    tail          = expected_utf.pop_back();
                    tail.out_last = 1'b1;
                    expected_utf.push_back(tail);
                end
                held_lead = '0;
                lead_held = 1'b0;
                dropping  = 1'b0;
            end
        endfunction

        task check_utf(out_word_t got);
            out_word_t want;
            if (expected_utf.size() == 0) begin
                report_mismatch($sformatf("unexpected word %02h valid %0b last %0b",
                                          got.out_byte, got.byte_valid, got.out_last));
                return;
            end
            want = expected_utf.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                report_mismatch($sformatf("byte_valid %0b, want %0b",
                                          got.byte_valid, want.byte_valid));
            if (got.out_last !== want.out_last)
                report_mismatch($sformatf("out_last %0b, want %0b",
                                          got.out_last, want.out_last));
        endtask
    endclass

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      latin_valid = 1'b0;
    logic      latin_stall;
    in_word_t  latin_word  = '0;
    logic      utf_valid;
    logic      utf_stall   = 1'b0;
    out_word_t utf_word;

    utf_scoreboard sb;
    bit idle_en      = 1'b1;
    int words_sent   = 0;
    int strings_sent = 0;
    int cycle_count  = 0;

    latin1_to_utf8_converter_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .latin_valid (latin_valid),
        .latin_stall (latin_stall),
        .latin_word  (latin_word),
        .utf_valid   (utf_valid),
        .utf_stall   (utf_stall),
        .utf_word    (utf_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("latin1_to_utf8_converter_top_test: errors");
        $finish;
    end

    // utf side: take words and stall at random
    always @(posedge clk)
    begin
        if (rst_n && utf_valid && !utf_stall)
            sb.check_utf(utf_word);
        if (idle_en && $urandom_range(99) < IDLE_PCT)
            utf_stall <= 1'b1;
        else
            utf_stall <= 1'b0;
    end

    task automatic send_latin(input logic [7:0] b, input logic lst);
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            latin_valid <= 1'b0;
            @(posedge clk);
        end
        latin_valid <= 1'b1;
        latin_word  <= '{data_byte: b, last_byte: lst};
        @(posedge clk);
        while (latin_stall)
            @(posedge clk);
        sb.note_latin(latin_word);
        words_sent++;
        if (lst)
            strings_sent++;
    endtask

    task automatic send_directed();
        logic [7:0] bytes[$];
        bit         lasts[$];
        bytes = '{8'h41, 8'h0A, 8'h01, 8'h1F, 8'h7F, 8'h20, 8'h80, 8'hFF, 8'hC2, 8'hA9,
                  8'hC3, 8'hBF, 8'hC2, 8'h41, 8'hC3, 8'hC3, 8'h80, 8'h7E,
                  8'hC2, 8'hFF, 8'hC3, 8'hC2, 8'h00, 8'hC5, 8'h41, 8'h00};
        lasts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
        foreach (bytes[i])
            send_latin(bytes[i], lasts[i]);
    endtask

    // mostly text-like strings, some raw noise strings
    task automatic send_random_text(input int target);
        logic [7:0] text[$];
        int         len;
        int         pick;
        bit         noise;
        while (words_sent < target)
        begin
            text.delete();
            len   = $urandom_range(1, 12);
            noise = ($urandom_range(9) == 0);
            while (text.size() < len)
            begin
                pick = $urandom_range(99);
                if (noise || pick >= 84)
                    text.push_back(8'($urandom_range(255)));
                else if (pick < 40)
                    text.push_back(8'($urandom_range(8'h20, 8'h7E)));
                else if (pick < 50)
                    text.push_back(8'($urandom_range(8'h80, 8'hFF)));
                else if (pick < 62)
                begin
                    text.push_back(LEAD_BASE | 8'($urandom_range(1)));
                    text.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                else if (pick < 68)
                begin
                    text.push_back(LEAD_BASE | 8'($urandom_range(1)));
                    text.push_back(8'($urandom_range(255)));
                end
                else if (pick < 74)
                    text.push_back(8'($urandom_range(8'h01, 8'h1F)));
                else if (pick < 78)
                    text.push_back(BYTE_LF);
                else if (pick < 81)
                    text.push_back(BYTE_DEL);
                else
                    text.push_back(BYTE_NUL);
            end
            foreach (text[i])
            begin
                idle_en = !(words_sent >= 90 && words_sent < 160);
                send_latin(text[i], i == text.size() - 1);
            end
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        sb = new;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        send_random_text(words_sent + RANDOM_WORDS);
        latin_valid <= 1'b0;
        while (sb.expected_utf.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d latin words in %0d strings, %0d utf words checked, %0d mismatches",
                 words_sent, strings_sent, sb.checked, sb.errors);
        $display("covered lead pairs, broken leads, control bytes, zero cutoff, bare markers");
        if (sb.errors == 0)
            $display("latin1_to_utf8_converter_top_test: clean");
        else
            $display("latin1_to_utf8_converter_top_test: errors");
        $finish;
    end

endmodule
